[sv/adsr_pkg.sv]
// Shared codes, widths and reset values for the linear ADSR envelope generator.
package adsr_pkg;

  localparam int unsigned DUR_W   = 20;
  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned PROD_W  = DUR_W + LEVEL_W;
  localparam int unsigned DIV_STEPS = LEVEL_W;

  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  localparam logic [LEVEL_W-1:0] FULL_SCALE  = 16'd32768;
  localparam logic [LEVEL_W-1:0] FLOOR_LEVEL = 16'd3;

  localparam logic [OP_W-1:0] OP_QUERY    = 2'd0;
  localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd1;
  localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd2;

  localparam logic [PHASE_W-1:0] PH_ATTACK  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_DECAY   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_SUSTAIN = 2'd2;
  localparam logic [PHASE_W-1:0] PH_RELEASE = 2'd3;

  localparam logic [2:0] REG_ATTACK  = 3'd0;
  localparam logic [2:0] REG_DECAY   = 3'd1;
  localparam logic [2:0] REG_RELEASE = 3'd2;
  localparam logic [2:0] REG_START   = 3'd3;
  localparam logic [2:0] REG_SUSTAIN = 3'd4;

  localparam logic [DUR_W-1:0]   RST_ATTACK  = 20'd4410;
  localparam logic [DUR_W-1:0]   RST_DECAY   = 20'd441;
  localparam logic [DUR_W-1:0]   RST_RELEASE = 20'd8820;
  localparam logic [LEVEL_W-1:0] RST_START   = 16'd32768;
  localparam logic [LEVEL_W-1:0] RST_SUSTAIN = 16'd26214;

  function automatic logic [LEVEL_W-1:0] sat_level(input logic [LEVEL_W-1:0] v);
    sat_level = (v > FULL_SCALE) ? FULL_SCALE : v;
  endfunction

endpackage

[sv/adsr_envelope_generator.sv]
// Linear ADSR envelope generator: APB registers, sequencer, multiplier and serial divider.
//
//  channel   | direction | transfer / contents
//  ----------+-----------+---------------------------------------------------
//  s_axis    | in        | tdata = now_tick[31:0], tuser = op[1:0]
//  m_axis    | out       | tdata = amplitude[15:0], tuser = phase[1:0]
//  apb       | in/out    | five registers at byte addresses 0,4,8,12,16
//
// An item passes from input transfer to result through accept, tick
// difference, classify, multiply, 16 restoring divider steps and finish.
// Items with no quotient go from classify straight to finish.
// s_axis_tready is high only while the sequencer is idle.
// A finished result waits in the output register; the next item may be
// accepted meanwhile and waits in its finish step until the register frees.
// Reset is asynchronous, active low, and restores the register defaults.
module adsr_envelope_generator #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // stream in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [adsr_pkg::TICK_W-1:0]   s_axis_tdata,  // [31:0] now_tick
  input  logic [adsr_pkg::OP_W-1:0]     s_axis_tuser,  // [1:0] op
  // stream out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [adsr_pkg::LEVEL_W-1:0]  m_axis_tdata,  // [15:0] amplitude
  output logic [adsr_pkg::PHASE_W-1:0]  m_axis_tuser,  // [1:0] phase
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [adsr_pkg::APB_AW-1:0]   paddr,
  input  logic [adsr_pkg::APB_DW-1:0]   pwdata,
  output logic [adsr_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import adsr_pkg::*;

  localparam int unsigned TW = (TIME_BITS < TICK_W) ? TIME_BITS : TICK_W;
  localparam int unsigned CW = (TW > DUR_W + 1) ? TW : DUR_W + 1;
  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_CLASS,
    S_MUL,
    S_DIV,
    S_FIN
  } state_e;

  // configuration registers
  logic [DUR_W-1:0]   attack_q, decay_q, release_q;
  logic [LEVEL_W-1:0] start_q, sustain_q;
  logic               wr_en;
  logic [2:0]         reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= RST_ATTACK;
      decay_q   <= RST_DECAY;
      release_q <= RST_RELEASE;
      start_q   <= RST_START;
      sustain_q <= RST_SUSTAIN;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ATTACK:  attack_q  <= pwdata[DUR_W-1:0];
        REG_DECAY:   decay_q   <= pwdata[DUR_W-1:0];
        REG_RELEASE: release_q <= pwdata[DUR_W-1:0];
        REG_START:   start_q   <= pwdata[LEVEL_W-1:0];
        REG_SUSTAIN: sustain_q <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ATTACK:  prdata = APB_DW'(attack_q);
      REG_DECAY:   prdata = APB_DW'(decay_q);
      REG_RELEASE: prdata = APB_DW'(release_q);
      REG_START:   prdata = APB_DW'(start_q);
      REG_SUSTAIN: prdata = APB_DW'(sustain_q);
      default:     prdata = '0;
    endcase
  end

  // datapath state
  state_e             state_q;
  logic               gate_q;
  logic [TW-1:0]      on_tick_q, off_tick_q, now_q;
  logic [TW-1:0]      diff_q;
  logic               early_q;
  logic [DUR_W-1:0]   x_q, den_q;
  logic [LEVEL_W-1:0] y_q, base_q, lo_q;
  logic               neg_q;
  logic [PHASE_W-1:0] phase_q;
  logic [DUR_W-1:0]   rem_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               out_valid_q;
  logic [LEVEL_W-1:0] out_amp_q;
  logic [PHASE_W-1:0] out_phase_q;

  logic [TW-1:0]      now_in, ref_tick;
  logic [TW:0]        diff_full;

  assign now_in    = s_axis_tdata[TW-1:0];
  assign ref_tick  = gate_q ? on_tick_q : off_tick_q;
  assign diff_full = {1'b0, now_q} - {1'b0, ref_tick};

  // classification
  logic [LEVEL_W-1:0] st_lvl, su_lvl;
  logic [CW-1:0]      life_x, att_x, ad_x, rel_x, dec_d, rel_d;
  logic               c_direct, c_neg;
  logic [LEVEL_W-1:0] c_base, c_y;
  logic [DUR_W-1:0]   c_x, c_den;
  logic [PHASE_W-1:0] c_phase;

  assign st_lvl = sat_level(start_q);
  assign su_lvl = sat_level(sustain_q);
  assign life_x = CW'(diff_q);
  assign att_x  = CW'(attack_q);
  assign ad_x   = CW'({1'b0, attack_q} + {1'b0, decay_q});
  assign rel_x  = CW'(release_q);
  assign dec_d  = life_x - att_x;
  assign rel_d  = rel_x - life_x;

  always_comb begin
    c_direct = 1'b1;
    c_neg    = 1'b0;
    c_base   = '0;
    c_x      = '0;
    c_y      = '0;
    c_den    = '0;
    c_phase  = PH_ATTACK;
    if (gate_q) begin
      priority if (early_q) begin
        c_base = '0;
      end else if (life_x <= att_x) begin
        if (attack_q == '0) begin
          c_base = FULL_SCALE;
        end else begin
          c_direct = 1'b0;
          c_x      = life_x[DUR_W-1:0];
          c_y      = FULL_SCALE;
          c_den    = attack_q;
        end
      end else if (life_x <= ad_x) begin
        c_phase  = PH_DECAY;
        c_direct = 1'b0;
        c_x      = dec_d[DUR_W-1:0];
        c_y      = (su_lvl >= st_lvl) ? su_lvl - st_lvl : st_lvl - su_lvl;
        c_den    = decay_q;
        c_base   = st_lvl;
        c_neg    = su_lvl < st_lvl;
      end else begin
        c_phase = PH_SUSTAIN;
        c_base  = su_lvl;
      end
    end else begin
      c_phase = PH_RELEASE;
      if (!early_q && (life_x < rel_x)) begin
        c_direct = 1'b0;
        c_x      = rel_d[DUR_W-1:0];
        c_y      = su_lvl;
        c_den    = release_q;
      end
    end
  end

  // shared multiplier and divider step
  logic [PROD_W-1:0]  prod;
  logic [DUR_W:0]     trial;
  logic               take;
  logic [LEVEL_W-1:0] amp_raw;

  assign prod    = PROD_W'(x_q) * PROD_W'(y_q);
  assign trial   = {rem_q, lo_q[LEVEL_W-1]};
  assign take    = trial >= {1'b0, den_q};
  assign amp_raw = neg_q ? base_q - lo_q : base_q + lo_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_amp_q;
  assign m_axis_tuser  = out_phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gate_q      <= 1'b0;
      on_tick_q   <= '0;
      off_tick_q  <= '0;
      now_q       <= '0;
      diff_q      <= '0;
      early_q     <= 1'b0;
      x_q         <= '0;
      den_q       <= '0;
      y_q         <= '0;
      base_q      <= '0;
      lo_q        <= '0;
      neg_q       <= 1'b0;
      phase_q     <= PH_ATTACK;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
      out_amp_q   <= '0;
      out_phase_q <= PH_ATTACK;
      cnt_q       <= '0;
    end else begin
      // in the finish step the output register is reloaded instead
      if (out_valid_q && m_axis_tready && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            now_q <= now_in;
            if (s_axis_tuser == OP_NOTE_ON) begin
              on_tick_q <= now_in;
              gate_q    <= 1'b1;
            end else if (s_axis_tuser == OP_NOTE_OFF) begin
              off_tick_q <= now_in;
              gate_q     <= 1'b0;
            end
            state_q <= S_DIFF;
          end
        end
        S_DIFF: begin
          diff_q  <= diff_full[TW-1:0];
          early_q <= diff_full[TW];
          state_q <= S_CLASS;
        end
        S_CLASS: begin
          phase_q <= c_phase;
          base_q  <= c_base;
          neg_q   <= c_neg;
          x_q     <= c_x;
          y_q     <= c_y;
          den_q   <= c_den;
          if (c_direct) begin
            lo_q    <= '0;
            state_q <= S_FIN;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          // quotient stays below 2^16, so the high part is already below den
          rem_q   <= prod[PROD_W-1:LEVEL_W];
          lo_q    <= prod[LEVEL_W-1:0];
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q <= take ? DUR_W'(trial - {1'b0, den_q}) : trial[DUR_W-1:0];
          lo_q  <= {lo_q[LEVEL_W-2:0], take};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_amp_q   <= (amp_raw <= FLOOR_LEVEL) ? '0 : amp_raw;
            out_phase_q <= phase_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[tb/sv/adsr_env_checker.sv]
// Checker for the ADSR envelope generator: snoops APB writes, predicts each result, compares.
module adsr_env_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [adsr_pkg::TICK_W-1:0]   in_tick_i,
  input  logic [adsr_pkg::OP_W-1:0]     in_op_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [adsr_pkg::LEVEL_W-1:0]  out_amp_i,
  input  logic [adsr_pkg::PHASE_W-1:0]  out_phase_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [adsr_pkg::APB_AW-1:0]   paddr_i,
  input  logic [adsr_pkg::APB_DW-1:0]   pwdata_i,
  output int unsigned                   err_cnt_o,
  output int unsigned                   pending_o,
  output int unsigned                   checked_o
);
  import adsr_pkg::*;

  typedef struct packed {
    logic [LEVEL_W-1:0] amp;
    logic [PHASE_W-1:0] phase;
  } env_res_t;

  logic [DUR_W-1:0]   atk_q, dec_q, rel_q;
  logic [LEVEL_W-1:0] start_q, sus_q;
  logic               gate_q;
  logic [TICK_W-1:0]  on_tick_q, off_tick_q;
  env_res_t           env_due_q[$];

  function automatic env_res_t envelope_at(input logic gate, input logic [TICK_W-1:0] on_t,
                                           input logic [TICK_W-1:0] off_t,
                                           input logic [TICK_W-1:0] now);
    env_res_t    r;
    logic [63:0] lvl, span, sus, st, atk, dec, rel;
    atk = 64'(atk_q);
    dec = 64'(dec_q);
    rel = 64'(rel_q);
    sus = (sus_q > FULL_SCALE) ? 64'(FULL_SCALE) : 64'(sus_q);
    st  = (start_q > FULL_SCALE) ? 64'(FULL_SCALE) : 64'(start_q);
    lvl = '0;
    if (gate) begin
      r.phase = PH_ATTACK;
      if (now >= on_t) begin
        span = 64'(now - on_t);
        if (span <= atk) begin
          // zero attack saturates the quotient
          lvl = (atk == 0) ? 64'(FULL_SCALE) : (span * 64'(FULL_SCALE)) / atk;
          if (lvl > 64'(FULL_SCALE)) lvl = 64'(FULL_SCALE);
        end else if (span <= atk + dec) begin
          r.phase = PH_DECAY;
          span = span - atk;
          if (sus >= st) lvl = st + (span * (sus - st)) / dec;
          else lvl = st - (span * (st - sus)) / dec;
        end else begin
          r.phase = PH_SUSTAIN;
          lvl = sus;
        end
      end
    end else begin
      r.phase = PH_RELEASE;
      if (now >= off_t) begin
        span = 64'(now - off_t);
        if (span < rel) lvl = (sus * (rel - span)) / rel;
      end
    end
    if (lvl <= 64'(FLOOR_LEVEL)) lvl = '0;
    r.amp = lvl[LEVEL_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    env_res_t          want;
    logic              gate_n;
    logic [TICK_W-1:0] on_n, off_n;
    if (!rst_ni) begin
      atk_q      = RST_ATTACK;
      dec_q      = RST_DECAY;
      rel_q      = RST_RELEASE;
      start_q    = RST_START;
      sus_q      = RST_SUSTAIN;
      gate_q     = 1'b0;
      on_tick_q  = '0;
      off_tick_q = '0;
      env_due_q.delete();
      err_cnt_o  = 0;
      pending_o  = 0;
      checked_o  = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[APB_AW-1:2])
          REG_ATTACK:  atk_q   = pwdata_i[DUR_W-1:0];
          REG_DECAY:   dec_q   = pwdata_i[DUR_W-1:0];
          REG_RELEASE: rel_q   = pwdata_i[DUR_W-1:0];
          REG_START:   start_q = pwdata_i[LEVEL_W-1:0];
          REG_SUSTAIN: sus_q   = pwdata_i[LEVEL_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (env_due_q.size() == 0) begin
          err_cnt_o++;
          if (err_cnt_o <= 40)
            $display("%0t checker: unexpected result amp %0d phase %0d", $time, out_amp_i,
                     out_phase_i);
        end else begin
          want = env_due_q.pop_front();
          checked_o++;
          if (out_amp_i !== want.amp) begin
            err_cnt_o++;
            if (err_cnt_o <= 40)
              $display("%0t checker: amplitude expected %0d got %0d", $time, want.amp,
                       out_amp_i);
          end
          if (out_phase_i !== want.phase) begin
            err_cnt_o++;
            if (err_cnt_o <= 40)
              $display("%0t checker: phase expected %0d got %0d", $time, want.phase,
                       out_phase_i);
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        gate_n = gate_q;
        on_n   = on_tick_q;
        off_n  = off_tick_q;
        if (in_op_i == OP_NOTE_ON) begin
          gate_n = 1'b1;
          on_n   = in_tick_i;
        end else if (in_op_i == OP_NOTE_OFF) begin
          gate_n = 1'b0;
          off_n  = in_tick_i;
        end
        env_due_q.push_back(envelope_at(gate_n, on_n, off_n, in_tick_i));
        gate_q     = gate_n;
        on_tick_q  = on_n;
        off_tick_q = off_n;
      end
      pending_o = env_due_q.size();
    end
  end

endmodule

[tb/sv/tb_top.sv]
// Testbench top for the ADSR envelope generator: clock, reset, stimulus and verdict.
module tb_top;
  import adsr_pkg::*;

  localparam int unsigned RUN_LIMIT  = 1_000_000;
  localparam int unsigned ROUNDS     = 12;
  localparam int unsigned ROUND_ITEMS = 157;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  logic                clk_i, rst_ni;
  logic                s_axis_tvalid, s_axis_tready;
  logic [TICK_W-1:0]   s_axis_tdata;   // [31:0] now_tick
  logic [OP_W-1:0]     s_axis_tuser;   // [1:0] op
  logic                m_axis_tvalid, m_axis_tready;
  logic [LEVEL_W-1:0]  m_axis_tdata;   // [15:0] amplitude
  logic [PHASE_W-1:0]  m_axis_tuser;   // [1:0] phase
  logic                psel, penable, pwrite, pready;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata, prdata;

  int unsigned err_cnt, pending, checked;
  int unsigned idle_pct, stall_pct, hold_req, hold_left;
  int unsigned n_items, n_on, n_off, n_writes, n_settings, cycle_cnt;

  // stimulus-side copy of the envelope timing, used only to aim ticks
  logic [DUR_W-1:0] atk_set, dec_set, rel_set;

  adsr_envelope_generator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  adsr_env_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_tick_i   (s_axis_tdata),
    .in_op_i     (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_amp_i   (m_axis_tdata),
    .out_phase_i (m_axis_tuser),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < RUN_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb_top: timeout after %0d cycles", RUN_LIMIT);
    $display("tb_top: done, errors");
    $finish;
  end

  // output side: random stalls, plus a long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [TICK_W-1:0] tick);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= tick;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    n_items++;
    if (op == OP_NOTE_ON) n_on++;
    if (op == OP_NOTE_OFF) n_off++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [APB_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_writes++;
    case (idx)
      REG_ATTACK:  atk_set = val[DUR_W-1:0];
      REG_DECAY:   dec_set = val[DUR_W-1:0];
      REG_RELEASE: rel_set = val[DUR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [DUR_W-1:0] atk, input logic [DUR_W-1:0] dec,
                           input logic [DUR_W-1:0] rel, input logic [LEVEL_W-1:0] st,
                           input logic [LEVEL_W-1:0] sus);
    wait_idle();
    // junk above the field width must be dropped
    apb_write(REG_ATTACK,  {12'($urandom), atk});
    apb_write(REG_DECAY,   {12'($urandom), dec});
    apb_write(REG_RELEASE, {12'($urandom), rel});
    apb_write(REG_START,   {16'($urandom), st});
    apb_write(REG_SUSTAIN, {16'($urandom), sus});
    if ($urandom_range(2) == 0) apb_write(REG_SUSTAIN + 3'($urandom_range(1, 3)), $urandom);
    n_settings++;
  endtask

  function automatic logic [DUR_W-1:0] pick_dur();
    case ($urandom_range(11))
      0:       return '0;
      1:       return DUR_W'(1);
      2:       return '1;
      3:       return DUR_W'($urandom);
      default: return DUR_W'($urandom_range(1, 3000));
    endcase
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(9))
      0:       return '0;
      1:       return FULL_SCALE;
      2:       return LEVEL_W'($urandom_range(32769, 65535));
      default: return LEVEL_W'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [TICK_W-1:0] life_offset();
    logic [TICK_W-1:0] a, d;
    a = TICK_W'(atk_set);
    d = TICK_W'(dec_set);
    case ($urandom_range(9))
      0:       return '0;
      1:       return a;
      2:       return a + 1;
      3:       return a + d;
      4:       return a + d + 1;
      5, 6:    return TICK_W'($urandom_range(0, a));
      7:       return a + TICK_W'($urandom_range(0, d));
      8:       return TICK_W'($urandom_range(0, 4 * (a + d) + 10));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TICK_W-1:0] release_offset();
    logic [TICK_W-1:0] r;
    r = TICK_W'(rel_set);
    case ($urandom_range(9))
      0:          return '0;
      1:          return r - 1;
      2:          return r;
      3:          return r + 1;
      4, 5, 6, 7: return TICK_W'($urandom_range(0, r));
      8:          return TICK_W'($urandom_range(0, 2 * r + 10));
      default:    return $urandom;
    endcase
  endfunction

  // one note: trigger, queries through attack/decay/sustain, release, queries after
  task automatic play_note();
    logic [TICK_W-1:0] t_on, t_off;
    t_on = $urandom;
    if ($urandom_range(7) == 0) send_item(OP_QUERY, t_on - TICK_W'($urandom_range(1, 50)));
    send_item(OP_NOTE_ON, t_on);
    repeat ($urandom_range(1, 6))
      send_item(($urandom_range(9) == 0) ? OP_SPARE : OP_QUERY, t_on + life_offset());
    if ($urandom_range(5) == 0) begin
      t_on = t_on + life_offset();
      send_item(OP_NOTE_ON, t_on);
      send_item(OP_QUERY, t_on + life_offset());
    end
    t_off = t_on + life_offset();
    send_item(OP_NOTE_OFF, t_off);
    if ($urandom_range(7) == 0) send_item(OP_QUERY, t_off - 1);
    repeat ($urandom_range(1, 5)) send_item(OP_QUERY, t_off + release_offset());
  endtask

  initial begin
    int unsigned target;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_QUERY;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    n_items = 0;
    n_on = 0;
    n_off = 0;
    n_writes = 0;
    n_settings = 1;
    atk_set = RST_ATTACK;
    dec_set = RST_DECAY;
    rel_set = RST_RELEASE;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: release from reset, spare op, full note with boundaries, wrap
    send_item(OP_QUERY, 32'd0);
    send_item(OP_SPARE, 32'd100);
    send_item(OP_NOTE_ON, 32'd1000);
    send_item(OP_QUERY, 32'd999);
    send_item(OP_QUERY, 32'd3205);
    send_item(OP_QUERY, 32'd5410);
    send_item(OP_QUERY, 32'd5630);
    send_item(OP_QUERY, 32'd5851);
    send_item(OP_QUERY, 32'd5852);
    send_item(OP_NOTE_OFF, 32'd20000);
    send_item(OP_QUERY, 32'd19999);
    send_item(OP_QUERY, 32'd28819);
    send_item(OP_QUERY, 32'd28820);
    send_item(OP_NOTE_ON, 32'hFFFF_FFFF);
    send_item(OP_QUERY, 32'd0);

    // zero durations, start above full scale, zero sustain
    write_all('0, '0, '0, 16'hFFFF, '0);
    send_item(OP_NOTE_ON, 32'd5000);
    send_item(OP_QUERY, 32'd5001);
    send_item(OP_NOTE_OFF, 32'd6000);

    // longest durations, rising decay, sustain above full scale
    write_all('1, '1, '1, '0, 16'd40000);
    send_item(OP_NOTE_ON, 32'd0);
    send_item(OP_QUERY, 32'd1048575);
    send_item(OP_QUERY, 32'd1572864);
    send_item(OP_QUERY, 32'h0020_0000);
    send_item(OP_NOTE_OFF, 32'h8000_0000);
    send_item(OP_QUERY, 32'h8000_0001);
    send_item(OP_QUERY, 32'hFFFF_FFFF);

    for (int rnd = 0; rnd < ROUNDS; rnd++) begin
      write_all(pick_dur(), pick_dur(), pick_dur(), pick_level(), pick_level());
      case (rnd % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 83; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 83; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      // output held off while input keeps offering
      if (rnd == 4) hold_req = 400;
      target = n_items + ROUND_ITEMS;
      while (n_items < target) begin
        if (rnd == 6 && n_items >= target - ROUND_ITEMS / 2 && n_items < target - 60) begin
          wait_idle();
          target = target - 1;
        end
        if ($urandom_range(99) < 15) send_item(OP_W'($urandom_range(3)), $urandom);
        else play_note();
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("tb_top: %0d items (%0d note-on, %0d note-off), %0d results checked",
             n_items, n_on, n_off, checked);
    $display("tb_top: %0d register settings via %0d writes, four idle profiles, long hold-off",
             n_settings, n_writes);
    if (err_cnt == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
